// ----- rtl/wav_pcm_header_parser_unit_defines.svh -----
// ----------------------------------------------------------------------------
// wav pcm header parser assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_HEADER_PARSER_UNIT_DEFINES_SVH
`define WAV_PCM_HEADER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define WPH_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("wph check failed");
// next-cycle implication
`define WPH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("wph check failed");
`else
`define WPH_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define WPH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

// ----- rtl/wph_pkg.sv -----
// ----------------------------------------------------------------------------
// wph_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package wph_pkg;

	// result kinds
	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_AUDIO  = 2'd2;

	// tags, first byte in the low lane
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// last byte positions of the main header and of the data chunk header
	localparam logic [5:0] POS_HEAD_LAST  = 6'd35;
	localparam logic [5:0] POS_DSIZE_LAST = 6'd7;

	localparam int DIVIDEND_W = 32;
	localparam int FRAME_W    = 18;
	localparam int DIV_STEPS  = DIVIDEND_W;

	typedef struct packed {
		logic       head_byte;
		logic       dhdr_byte;
		logic [5:0] pos;
		logic       skip_load;
		logic       skip_dec;
		logic       div_start;
		logic       emit_reject;
		logic       emit_accept;
		logic       emit_audio;
	} wph_cmd_t;

	typedef struct packed {
		logic head_ok;
		logic tag_ok;
		logic skip_none;
		logic skip_done;
		logic div_done;
		logic frames_zero;
		logic frame_end;
		logic frames_one;
		logic out_busy;
	} wph_sts_t;

endpackage

`default_nettype wire

// ----- rtl/wph_div.sv -----
// ----------------------------------------------------------------------------
// wph_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wph_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wph_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [wph_pkg::FRAME_W-1:0]     divisor,
	output logic                            done,
	output logic [wph_pkg::DIVIDEND_W-1:0]  quotient
);
	import wph_pkg::*;

	localparam int CW = $clog2(DIV_STEPS);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [FRAME_W-1:0]    rem_q;
	logic [FRAME_W-1:0]    dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [FRAME_W:0]      shifted;
	logic                  fits;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? FRAME_W'(shifted - {1'b0, dvs_q}) : shifted[FRAME_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/wph_ctrl.sv -----
// ----------------------------------------------------------------------------
// wph_ctrl
// parse phase sequencer, byte position and input flow control
// ----------------------------------------------------------------------------
`default_nettype none

module wph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              file_valid,
	input  logic              restart,
	input  wph_pkg::wph_sts_t sts,
	output logic              file_stall,
	output wph_pkg::wph_cmd_t cmd
);
	import wph_pkg::*;

	localparam logic [2:0] S_WAIT  = 3'd0;
	localparam logic [2:0] S_HEAD  = 3'd1;
	localparam logic [2:0] S_SKIP  = 3'd2;
	localparam logic [2:0] S_DHDR  = 3'd3;
	localparam logic [2:0] S_AUDIO = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;

	logic [2:0] state_q, state_d, cur_state;
	logic [5:0] pos_q, pos_d, cur_pos;
	logic       take;

	assign file_stall = (state_q == S_DIV) || sts.out_busy;
	assign take       = file_valid && !file_stall;

	// restart drops whatever was going on and starts a header at this byte
	assign cur_state = restart ? S_HEAD : state_q;
	assign cur_pos   = restart ? 6'd0 : pos_q;

	always_comb begin
		cmd     = '0;
		cmd.pos = cur_pos;
		state_d = state_q;
		pos_d   = pos_q;
		if (state_q == S_DIV) begin
			if (sts.div_done && !sts.out_busy) begin
				cmd.emit_accept = 1'b1;
				state_d = sts.frames_zero ? S_WAIT : S_AUDIO;
			end
		end else if (take) begin
			case (cur_state)
				S_HEAD: begin
					if (!sts.head_ok) begin
						cmd.emit_reject = 1'b1;
						state_d = S_WAIT;
						pos_d   = 6'd0;
					end else begin
						cmd.head_byte = 1'b1;
						if (cur_pos == POS_HEAD_LAST) begin
							cmd.skip_load = 1'b1;
							pos_d   = 6'd0;
							state_d = sts.skip_none ? S_DHDR : S_SKIP;
						end else begin
							pos_d   = cur_pos + 6'd1;
							state_d = S_HEAD;
						end
					end
				end
				S_SKIP: begin
					cmd.skip_dec = 1'b1;
					if (sts.skip_done) begin
						pos_d   = 6'd0;
						state_d = S_DHDR;
					end
				end
				S_DHDR: begin
					if (cur_pos < 6'd4 && !sts.tag_ok) begin
						cmd.emit_reject = 1'b1;
						state_d = S_WAIT;
						pos_d   = 6'd0;
					end else begin
						cmd.dhdr_byte = 1'b1;
						if (cur_pos == POS_DSIZE_LAST) begin
							cmd.div_start = 1'b1;
							pos_d   = 6'd0;
							state_d = S_DIV;
						end else begin
							pos_d = cur_pos + 6'd1;
						end
					end
				end
				S_AUDIO: begin
					cmd.emit_audio = 1'b1;
					if (sts.frame_end && sts.frames_one) begin
						state_d = S_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			pos_q   <= 6'd0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wph_dp.sv -----
// ----------------------------------------------------------------------------
// wph_dp
// header field capture, byte checks, counters, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module wph_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        file_byte,
	input  wph_pkg::wph_cmd_t cmd,
	input  logic              res_stall,
	output wph_pkg::wph_sts_t sts,
	output logic              res_valid,
	output logic [1:0]        kind,
	output logic [7:0]        audio_byte,
	output logic [31:0]       sample_rate,
	output logic [15:0]       channel_count,
	output logic [1:0]        bytes_per_sample,
	output logic [31:0]       frame_count,
	output logic              last
);
	import wph_pkg::*;

	logic [31:0]         fmt_q;
	logic [15:0]         ch_q;
	logic [31:0]         rate_q;
	logic [1:0]          sbytes_q;
	logic [FRAME_W-1:0]  fsz_q;
	logic [31:0]         skip_q;
	logic [23:0]         dsize_q;
	logic [31:0]         frames_q;
	logic [FRAME_W-1:0]  bif_q;

	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [FRAME_W-1:0]    fsz_new;
	logic [4:0]            lane;
	logic                  head_ok;
	logic                  frame_end;
	logic                  last_byte;

	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  audio_q;
	logic [31:0] rate_out_q;
	logic [15:0] ch_out_q;
	logic [1:0]  bps_out_q;
	logic [31:0] frames_out_q;
	logic        last_q;

	wph_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({file_byte, dsize_q}),
		.divisor  (fsz_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign lane = {cmd.pos[1:0], 3'b000};

	// header byte checks by position
	always_comb begin
		case (cmd.pos) inside
			[6'd0:6'd3]:   head_ok = file_byte == TAG_RIFF[lane +: 8];
			[6'd4:6'd7]:   head_ok = 1'b1;
			[6'd8:6'd11]:  head_ok = file_byte == TAG_WAVE[lane +: 8];
			[6'd12:6'd15]: head_ok = file_byte == TAG_FMT[lane +: 8];
			[6'd16:6'd18]: head_ok = 1'b1;
			6'd19:         head_ok = (file_byte != 8'd0) || (fmt_q[23:8] != 16'd0)
			                         || (fmt_q[7:4] != 4'd0);
			6'd20:         head_ok = file_byte == 8'd1;
			6'd21:         head_ok = file_byte == 8'd0;
			6'd22:         head_ok = 1'b1;
			6'd23:         head_ok = (file_byte != 8'd0) || (ch_q[7:0] != 8'd0);
			[6'd24:6'd26]: head_ok = 1'b1;
			6'd27:         head_ok = (file_byte != 8'd0) || (rate_q[23:0] != 24'd0);
			[6'd28:6'd33]: head_ok = 1'b1;
			6'd34:         head_ok = (file_byte == 8'd8) || (file_byte == 8'd16)
			                         || (file_byte == 8'd24);
			6'd35:         head_ok = file_byte == 8'd0;
			default:       head_ok = 1'b0;
		endcase
	end

	// channels times one, two or three bytes
	assign fsz_new = (file_byte[4] ? {1'b0, ch_q, 1'b0} : {FRAME_W{1'b0}})
	               + (file_byte[3] ? {2'b00, ch_q} : {FRAME_W{1'b0}});

	assign frame_end = ({1'b0, bif_q} + {{FRAME_W{1'b0}}, 1'b1}) >= {1'b0, fsz_q};
	assign last_byte = frame_end && (frames_q == 32'd1);

	always_comb begin
		sts             = '0;
		sts.head_ok     = head_ok;
		sts.tag_ok      = file_byte == TAG_DATA[lane +: 8];
		sts.skip_none   = fmt_q == 32'd16;
		sts.skip_done   = skip_q == 32'd1;
		sts.div_done    = div_done;
		sts.frames_zero = quotient == '0;
		sts.frame_end   = frame_end;
		sts.frames_one  = frames_q == 32'd1;
		sts.out_busy    = res_valid_q && res_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.head_byte) begin
			case (cmd.pos) inside
				[6'd16:6'd19]: fmt_q[lane +: 8] <= file_byte;
				[6'd22:6'd23]: ch_q[{cmd.pos[0], 3'b000} +: 8] <= file_byte;
				[6'd24:6'd27]: rate_q[lane +: 8] <= file_byte;
				6'd34: begin
					sbytes_q <= file_byte[4:3];
					fsz_q    <= fsz_new;
				end
				default: ;
			endcase
		end
		if (cmd.skip_load) begin
			skip_q <= fmt_q - 32'd16;
		end else if (cmd.skip_dec) begin
			skip_q <= skip_q - 32'd1;
		end
		if (cmd.dhdr_byte && cmd.pos[2] && (cmd.pos[1:0] != 2'd3)) begin
			dsize_q[lane +: 8] <= file_byte;
		end
		if (cmd.emit_accept) begin
			frames_q <= quotient;
			bif_q    <= '0;
		end else if (cmd.emit_audio) begin
			if (frame_end) begin
				bif_q    <= '0;
				frames_q <= frames_q - 32'd1;
			end else begin
				bif_q <= bif_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_reject || cmd.emit_accept || cmd.emit_audio) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_accept) begin
			kind_q       <= KIND_ACCEPT;
			audio_q      <= 8'd0;
			rate_out_q   <= rate_q;
			ch_out_q     <= ch_q;
			bps_out_q    <= sbytes_q;
			frames_out_q <= quotient;
			last_q       <= 1'b0;
		end else if (cmd.emit_audio) begin
			kind_q       <= KIND_AUDIO;
			audio_q      <= file_byte;
			rate_out_q   <= 32'd0;
			ch_out_q     <= 16'd0;
			bps_out_q    <= 2'd0;
			frames_out_q <= 32'd0;
			last_q       <= last_byte;
		end else if (cmd.emit_reject) begin
			kind_q       <= KIND_REJECT;
			audio_q      <= 8'd0;
			rate_out_q   <= 32'd0;
			ch_out_q     <= 16'd0;
			bps_out_q    <= 2'd0;
			frames_out_q <= 32'd0;
			last_q       <= 1'b0;
		end
	end

	assign res_valid        = res_valid_q;
	assign kind             = kind_q;
	assign audio_byte       = audio_q;
	assign sample_rate      = rate_out_q;
	assign channel_count    = ch_out_q;
	assign bytes_per_sample = bps_out_q;
	assign frame_count      = frames_out_q;
	assign last             = last_q;

endmodule

`default_nettype wire

// ----- rtl/wav_pcm_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// wav_pcm_header_parser_unit
// byte-serial wav pcm header check with audio pass-through
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  file      file_valid/file_stall   file_byte, restart
//  result    res_valid/res_stall     kind, audio_byte, sample_rate,
//                                    channel_count, bytes_per_sample,
//                                    frame_count, last
//
//  one file byte per cycle through header, skip, data header and audio
//  the frame count comes from a one bit per cycle divider: after the last
//  data-size byte the file side stalls through the divide and the accept beat
//  a full result register stalled downstream also stalls the file side
//  arst_n clears the phase, position and valid flags; no clearing pass
//
`default_nettype none

`include "wav_pcm_header_parser_unit_defines.svh"

module wav_pcm_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// file byte beats
	input  logic        file_valid,
	output logic        file_stall,
	input  logic [7:0]  file_byte,
	input  logic        restart,
	// result beats
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  audio_byte,
	output logic [31:0] sample_rate,
	output logic [15:0] channel_count,
	output logic [1:0]  bytes_per_sample,
	output logic [31:0] frame_count,
	output logic        last
);
	import wph_pkg::*;

	// commands from the sequencer, status back from the datapath
	wph_cmd_t cmd;
	wph_sts_t sts;

	// sequencer: phase, byte position, input stall
	wph_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.restart    (restart),
		.sts        (sts),
		.file_stall (file_stall),
		.cmd        (cmd)
	);

	// datapath: captured fields, byte checks, frame counters, divider, result beat
	wph_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.file_byte        (file_byte),
		.cmd              (cmd),
		.res_stall        (res_stall),
		.sts              (sts),
		.res_valid        (res_valid),
		.kind             (kind),
		.audio_byte       (audio_byte),
		.sample_rate      (sample_rate),
		.channel_count    (channel_count),
		.bytes_per_sample (bytes_per_sample),
		.frame_count      (frame_count),
		.last             (last)
	);

	// an accept beat only follows a header that passed every field check
	`WPH_ASSERT_IMP(a_accept_fields, clk, arst_n, res_valid && (kind == KIND_ACCEPT), (sample_rate != 32'd0) && (channel_count != 16'd0) && (bytes_per_sample != 2'd0))
	// the end-of-data mark only rides on audio beats
	`WPH_ASSERT_IMP(a_last_audio_only, clk, arst_n, res_valid && last, kind == KIND_AUDIO)
	// once the division starts no file byte is taken
	`WPH_ASSERT_NEXT(a_div_stalls_input, clk, arst_n, cmd.div_start, file_stall)

endmodule

`default_nettype wire

// ----- sim/wav_pcm_header_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// wav_pcm_header_parser_unit_tb
// self-checking bench: a short directed table of header corner cases, then
// randomly built wav files (mostly well formed, some corrupted, truncated or
// broken up by noise) fed byte by byte; every result beat is checked against
// a byte-level parser model kept in the bench or a value typed into the
// directed table, under random idling on both channels
// ----------------------------------------------------------------------------

module wav_pcm_header_parser_unit_tb;

	import wph_pkg::*;

	// parser phases of the bench model
	typedef enum logic [2:0] {
		WAIT_FILE, IN_HEADER, IN_SKIP, IN_DATA_HDR, IN_AUDIO
	} parse_phase_t;

	// how a beat is checked: by the model, or by a value typed into the table
	typedef enum logic [1:0] {ROW_MODEL, ROW_NO_BEAT, ROW_REJECT} row_check_t;

	typedef struct packed {
		logic [7:0] b;
		logic       rs;
		row_check_t how;
	} stim_row_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  audio;
		logic [31:0] rate;
		logic [15:0] chans;
		logic [1:0]  bps;
		logic [31:0] frames;
		logic        last;
	} wav_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        file_valid;
	logic        file_stall;
	logic [7:0]  file_byte;
	logic        restart;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  audio_byte;
	logic [31:0] sample_rate;
	logic [15:0] channel_count;
	logic [1:0]  bytes_per_sample;
	logic [31:0] frame_count;
	logic        last;

	// check mode of the byte currently offered, travels with the payload
	row_check_t row_how;

	// model state
	parse_phase_t wav_phase;
	logic [5:0]   hdr_pos;
	logic [31:0]  fmt_size;
	logic [15:0]  chan_cap;
	logic [31:0]  rate_cap;
	logic [1:0]   sbytes_cap;
	logic [31:0]  skip_left;
	logic [31:0]  data_size;
	logic [31:0]  frames_left;
	logic [17:0]  frame_byte;

	wav_result_t expected_results[$];
	wav_result_t pred;
	wav_result_t got;
	wav_result_t want;
	bit          has_beat;

	logic [7:0]  wav_bytes[$];
	int          beats_fed = 0;
	int          mismatches = 0;
	int          send_idle_pct;
	int          recv_idle_pct;

	// directed part: no-file bytes, first-byte reject, restart mid-file,
	// ignored riff size at its extreme, short format chunk
	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b0, ROW_NO_BEAT},	// no file open yet, dropped
		'{8'hFF, 1'b1, ROW_REJECT},	// bad first tag byte
		'{8'h00, 1'b0, ROW_NO_BEAT},	// dropped after a reject
		'{"R",   1'b1, ROW_MODEL},
		'{"I",   1'b0, ROW_MODEL},
		'{"R",   1'b1, ROW_MODEL},	// restart abandons the open file
		'{"I",   1'b0, ROW_MODEL},
		'{"F",   1'b0, ROW_MODEL},
		'{"F",   1'b0, ROW_MODEL},
		'{8'hFF, 1'b0, ROW_MODEL},	// riff size is not checked
		'{8'hFF, 1'b0, ROW_MODEL},
		'{8'hFF, 1'b0, ROW_MODEL},
		'{8'hFF, 1'b0, ROW_MODEL},
		'{"W",   1'b0, ROW_MODEL},
		'{"A",   1'b0, ROW_MODEL},
		'{"V",   1'b0, ROW_MODEL},
		'{"E",   1'b0, ROW_MODEL},
		'{"f",   1'b0, ROW_MODEL},
		'{"m",   1'b0, ROW_MODEL},
		'{"t",   1'b0, ROW_MODEL},
		'{" ",   1'b0, ROW_MODEL},
		'{8'h0F, 1'b0, ROW_MODEL},	// format size 15
		'{8'h00, 1'b0, ROW_MODEL},
		'{8'h00, 1'b0, ROW_MODEL},
		'{8'h00, 1'b0, ROW_REJECT}	// short format size fails on its last byte
	};

	wav_pcm_header_parser_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.file_valid       (file_valid),
		.file_stall       (file_stall),
		.file_byte        (file_byte),
		.restart          (restart),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.kind             (kind),
		.audio_byte       (audio_byte),
		.sample_rate      (sample_rate),
		.channel_count    (channel_count),
		.bytes_per_sample (bytes_per_sample),
		.frame_count      (frame_count),
		.last             (last)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- model

	function automatic void clear_parse();
		wav_phase   = WAIT_FILE;
		hdr_pos     = '0;
		fmt_size    = '0;
		chan_cap    = '0;
		rate_cap    = '0;
		sbytes_cap  = '0;
		skip_left   = '0;
		data_size   = '0;
		frames_left = '0;
		frame_byte  = '0;
	endfunction

	// checks and captures one byte of the 36-byte main header
	function automatic bit header_byte_ok(input int p, input logic [7:0] b);
		if (p < 4)
			return b == TAG_RIFF[8*p +: 8];
		if (p < 8)
			return 1'b1;
		if (p < 12)
			return b == TAG_WAVE[8*(p-8) +: 8];
		if (p < 16)
			return b == TAG_FMT[8*(p-12) +: 8];
		if (p < 20) begin
			fmt_size = fmt_size | ({24'h0, b} << (8*(p-16)));
			return p != 19 || fmt_size >= 32'd16;
		end
		// format tag must be 1; the low byte alone can already fail it
		if (p == 20)
			return b == 8'd1;
		if (p == 21)
			return b == 8'd0;
		if (p < 24) begin
			chan_cap = chan_cap | ({8'h0, b} << (8*(p-22)));
			return p != 23 || chan_cap != 16'd0;
		end
		if (p < 28) begin
			rate_cap = rate_cap | ({24'h0, b} << (8*(p-24)));
			return p != 27 || rate_cap != 32'd0;
		end
		// byte rate and block align are not checked
		if (p < 34)
			return 1'b1;
		if (p == 34) begin
			case (b)
				8'd8:    sbytes_cap = 2'd1;
				8'd16:   sbytes_cap = 2'd2;
				8'd24:   sbytes_cap = 2'd3;
				default: return 1'b0;
			endcase
			return 1'b1;
		end
		return b == 8'd0;
	endfunction

	// one file byte in, at most one result beat out
	function automatic bit predict_wav_byte(input logic [7:0] b, input logic rs,
			output wav_result_t r);
		logic [17:0] fsz;
		r = '0;
		if (rs) begin
			clear_parse();
			wav_phase = IN_HEADER;
		end
		case (wav_phase)
			IN_HEADER: begin
				if (!header_byte_ok(hdr_pos, b)) begin
					clear_parse();
					r.kind = KIND_REJECT;
					return 1'b1;
				end
				if (hdr_pos == POS_HEAD_LAST) begin
					skip_left = fmt_size - 32'd16;
					hdr_pos   = '0;
					wav_phase = (skip_left != 0) ? IN_SKIP : IN_DATA_HDR;
				end else begin
					hdr_pos++;
				end
				return 1'b0;
			end
			IN_SKIP: begin
				skip_left--;
				if (skip_left == 0) begin
					hdr_pos   = '0;
					wav_phase = IN_DATA_HDR;
				end
				return 1'b0;
			end
			IN_DATA_HDR: begin
				if (hdr_pos < 4) begin
					if (b != TAG_DATA[8*hdr_pos +: 8]) begin
						clear_parse();
						r.kind = KIND_REJECT;
						return 1'b1;
					end
					hdr_pos++;
					return 1'b0;
				end
				data_size = data_size | ({24'h0, b} << (8*(hdr_pos-4)));
				if (hdr_pos < POS_DSIZE_LAST) begin
					hdr_pos++;
					return 1'b0;
				end
				fsz         = sbytes_cap * chan_cap;
				frames_left = (fsz != 0) ? data_size / fsz : 32'd0;
				frame_byte  = '0;
				hdr_pos     = '0;
				r.kind      = KIND_ACCEPT;
				r.rate      = rate_cap;
				r.chans     = chan_cap;
				r.bps       = sbytes_cap;
				r.frames    = frames_left;
				// no whole frame of data: accept, then back to waiting
				wav_phase   = (frames_left != 0) ? IN_AUDIO : WAIT_FILE;
				return 1'b1;
			end
			IN_AUDIO: begin
				fsz     = sbytes_cap * chan_cap;
				r.kind  = KIND_AUDIO;
				r.audio = b;
				r.last  = (frames_left == 1) && (frame_byte + 1 >= fsz);
				frame_byte++;
				if (frame_byte >= fsz) begin
					frame_byte = '0;
					frames_left--;
					if (frames_left == 0)
						wav_phase = WAIT_FILE;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// -------------------------------------------------------- file builder

	function automatic void put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			wav_bytes.push_back(v[8*i +: 8]);
	endfunction

	// mostly well-formed files with random content; a share of broken fields,
	// corrupted headers, cut-off files and oversized chunks
	function automatic void build_wav_file();
		int unsigned fmt_len;
		int unsigned chans;
		int unsigned bits_val;
		int unsigned sbytes;
		int unsigned fsz;
		int unsigned nframes;
		int unsigned n;
		int unsigned k;
		wav_bytes.delete();
		put_le(TAG_RIFF, 4);
		put_le($urandom, 4);
		put_le(TAG_WAVE, 4);
		put_le(TAG_FMT, 4);
		k = $urandom_range(0, 19);
		fmt_len = (k == 0) ? $urandom_range(0, 15) :
			(k < 5) ? $urandom_range(17, 24) : (k == 5) ? $urandom : 16;
		put_le(fmt_len, 4);
		put_le(($urandom_range(0, 14) == 0) ? $urandom_range(0, 65535) : 1, 2);
		k = $urandom_range(0, 24);
		chans = (k == 0) ? 0 : (k == 1) ? 65535 :
			(k == 2) ? $urandom_range(1, 65535) : $urandom_range(1, 4);
		put_le(chans, 2);
		put_le(($urandom_range(0, 24) == 0) ? 0 : $urandom, 4);
		put_le($urandom, 4);	// byte rate
		put_le($urandom, 2);	// block align
		sbytes   = $urandom_range(1, 3);
		bits_val = 8 * sbytes;
		if ($urandom_range(0, 11) == 0)
			bits_val = $urandom_range(0, 65535);
		put_le(bits_val, 2);
		// extra format bytes; a huge format size gets only a few before the cut
		n = (fmt_len > 24) ? $urandom_range(1, 30) : (fmt_len > 16) ? fmt_len - 16 : 0;
		for (int i = 0; i < n; i++)
			wav_bytes.push_back(8'($urandom_range(0, 255)));
		put_le(TAG_DATA, 4);
		if ($urandom_range(0, 14) == 0)
			wav_bytes[wav_bytes.size() - 1 - $urandom_range(0, 3)] =
				8'($urandom_range(0, 255));
		fsz = (sbytes * chans != 0) ? sbytes * chans : 1;
		nframes = $urandom_range(0, 5);
		if ($urandom_range(0, 19) == 0)
			put_le($urandom, 4);
		else
			put_le(nframes * fsz + $urandom_range(0, fsz - 1), 4);
		// audio, capped for wide frames, plus a few trailing bytes to drop
		n = ((nframes * fsz > 64) ? 64 : nframes * fsz) + $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			wav_bytes.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			wav_bytes[$urandom_range(0, 35)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(1, wav_bytes.size());
			while (wav_bytes.size() > k)
				void'(wav_bytes.pop_back());
		end
	endfunction

	// ------------------------------------------------------------- driving

	// sender idles first lightly, then heavily, then not at all; the
	// receiver idles first heavily, then lightly, then not at all
	function automatic void pick_idle_mix();
		if (beats_fed < 433) begin
			send_idle_pct = 13;
			recv_idle_pct = 68;
		end else if (beats_fed < 866) begin
			send_idle_pct = 68;
			recv_idle_pct = 13;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endfunction

	// offer one file byte at the falling edge, hold it until taken
	task automatic feed_byte(input logic [7:0] b, input logic rs, input row_check_t how);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			file_valid <= 1'b0;
			@(negedge clk);
		end
		file_valid <= 1'b1;
		file_byte  <= b;
		restart    <= rs;
		row_how    <= how;
		do
			@(posedge clk);
		while (file_stall);
	endtask

	always @(negedge clk)
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// ------------------------------------------------------------ checking

	task automatic note_mismatch(input string what, input wav_result_t e,
			input wav_result_t a);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch, %s: expected kind=%0d byte=%h rate=%h ch=%0d bps=%0d",
				what, e.kind, e.audio, e.rate, e.chans, e.bps);
			$display("  frames=%0d last=%0b; got kind=%0d byte=%h rate=%h ch=%0d",
				e.frames, e.last, a.kind, a.audio, a.rate, a.chans);
			$display("  bps=%0d frames=%0d last=%0b", a.bps, a.frames, a.last);
		end
	endtask

	// file beats feed the model, result beats pop the oldest expectation;
	// both handled in one block so the order within the edge is fixed
	always @(posedge clk) begin
		if (!arst_n)
			clear_parse();
		if (arst_n && file_valid && !file_stall) begin
			// bytes with no file open are dropped and do not count
			if (restart || wav_phase != WAIT_FILE)
				beats_fed++;
			has_beat = predict_wav_byte(file_byte, restart, pred);
			case (row_how)
				ROW_MODEL:
					if (has_beat)
						expected_results.push_back(pred);
				ROW_REJECT: begin
					pred      = '0;
					pred.kind = KIND_REJECT;
					expected_results.push_back(pred);
				end
				default: ;
			endcase
		end
		if (arst_n && res_valid && !res_stall) begin
			got = '{kind, audio_byte, sample_rate, channel_count, bytes_per_sample,
				frame_count, last};
			if (expected_results.size() == 0) begin
				note_mismatch("beat with nothing expected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want)
					note_mismatch("field differs", want, got);
			end
		end
	end

	// ------------------------------------------------------------ stimulus

	initial begin
		arst_n        = 1'b0;
		file_valid    = 1'b0;
		file_byte     = 8'h00;
		restart       = 1'b0;
		row_how       = ROW_MODEL;
		send_idle_pct = 13;
		recv_idle_pct = 68;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			feed_byte(directed_rows[i].b, directed_rows[i].rs, directed_rows[i].how);

		// random files, each opened with restart, sometimes followed by noise
		while (beats_fed < 1300) begin
			pick_idle_mix();
			build_wav_file();
			foreach (wav_bytes[i])
				feed_byte(wav_bytes[i], i == 0, ROW_MODEL);
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 6))
					feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
						ROW_MODEL);
		end

		@(negedge clk);
		file_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// room for a late divide and any stray beat
		repeat (48) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
